[hdl/macd_pkg.sv]
// Shared types, widths and the control-store program of the MACD indicator stream.
// Depends on nothing; the top level macd_indicator_stream imports it.
`timescale 1ns / 1ps
`default_nettype none

package macd_pkg;

    // Number formats
    localparam int FRACTION_BITS = 24;
    localparam int PRICE_BITS    = 32;
    localparam int PRICE_SHIFT   = FRACTION_BITS - 8;
    localparam int AVG_W         = PRICE_BITS + PRICE_SHIFT;  // unsigned average
    localparam int OUT_W         = 52;                        // signed result fields
    localparam int MAG_W         = AVG_W + 2;                 // |x - avg| for any average
    localparam int LO_W          = (MAG_W + 1) / 2;
    localparam int HI_W          = MAG_W - LO_W;
    localparam int ALPHA_W       = 17;
    localparam int ALPHA_FRAC    = 16;
    localparam int PLO_W         = LO_W + ALPHA_W;
    localparam int PHI_W         = HI_W + ALPHA_W;
    localparam int SUM_W         = MAG_W + ALPHA_W;
    localparam int PERIOD_W      = 8;
    localparam int IDX_W         = 10;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = ALPHA_W;
    localparam int PHASE_W       = 2;
    localparam int STEP_W        = 5;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE  = ALPHA_W'(1 << ALPHA_FRAC);
    localparam logic [SUM_W-1:0]   ROUND_HALF = SUM_W'(1 << (ALPHA_FRAC - 1));
    localparam logic [IDX_W-1:0]   IDX_MAX    = {IDX_W{1'b1}};

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAST_PERIOD   = 3'd0,
        CFG_SLOW_PERIOD   = 3'd1,
        CFG_SIGNAL_PERIOD = 3'd2,
        CFG_FAST_ALPHA    = 3'd3,
        CFG_SLOW_ALPHA    = 3'd4,
        CFG_SIGNAL_ALPHA  = 3'd5
    } t_cfg_reg;

    typedef enum logic [PHASE_W-1:0] {
        PHASE_COLD   = 2'd0,
        PHASE_DIFF   = 2'd1,
        PHASE_SIGNAL = 2'd2
    } t_phase;

    // Datapath operations of one control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_DIFF,      // magnitude and sign of x - avg
        OP_MLO,       // low half partial product
        OP_MHI,       // high half partial product
        OP_SUM,       // combine partial products, round
        OP_APPLY,     // move average by the rounded step
        OP_SEED_AVG,  // fast = slow = price
        OP_DLINE,     // diff = fast - slow
        OP_SEED_SIG,  // signal = diff
        OP_OUT        // load result register, retire the item
    } t_op;

    typedef enum logic [1:0] {
        SEL_FAST,
        SEL_SLOW,
        SEL_SIG
    } t_sel;

    typedef enum logic [1:0] {
        J_NEXT,       // fall through
        J_ALWAYS,     // go to tgt_a
        J_SLOW,       // before slow seed: tgt_a, at seed: tgt_b, else next
        J_SIG         // before signal seed: tgt_a, at seed: tgt_b, else next
    } t_jmp;

    typedef struct packed {
        t_op               op;
        t_sel              sel;
        t_jmp              jmp;
        logic [STEP_W-1:0] tgt_a;
        logic [STEP_W-1:0] tgt_b;
    } t_uword;

    localparam logic [STEP_W-1:0] STEP_SEED_AVG = 5'd11;
    localparam logic [STEP_W-1:0] STEP_DLINE    = 5'd12;
    localparam logic [STEP_W-1:0] STEP_SEED_SIG = 5'd18;
    localparam logic [STEP_W-1:0] STEP_OUT      = 5'd19;
    localparam logic [STEP_W-1:0] STEP_NONE     = 5'd0;

    // Control store
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '{OP_NOP, SEL_FAST, J_ALWAYS, STEP_OUT, STEP_NONE};
        unique case (step)
            5'd0:  w = '{OP_NOP,      SEL_FAST, J_SLOW,   STEP_OUT, STEP_SEED_AVG};
            5'd1:  w = '{OP_DIFF,     SEL_FAST, J_NEXT,   STEP_NONE, STEP_NONE};
            5'd2:  w = '{OP_MLO,      SEL_FAST, J_NEXT,   STEP_NONE, STEP_NONE};
            5'd3:  w = '{OP_MHI,      SEL_FAST, J_NEXT,   STEP_NONE, STEP_NONE};
            5'd4:  w = '{OP_SUM,      SEL_FAST, J_NEXT,   STEP_NONE, STEP_NONE};
            5'd5:  w = '{OP_APPLY,    SEL_FAST, J_NEXT,   STEP_NONE, STEP_NONE};
            5'd6:  w = '{OP_DIFF,     SEL_SLOW, J_NEXT,   STEP_NONE, STEP_NONE};
            5'd7:  w = '{OP_MLO,      SEL_SLOW, J_NEXT,   STEP_NONE, STEP_NONE};
            5'd8:  w = '{OP_MHI,      SEL_SLOW, J_NEXT,   STEP_NONE, STEP_NONE};
            5'd9:  w = '{OP_SUM,      SEL_SLOW, J_NEXT,   STEP_NONE, STEP_NONE};
            5'd10: w = '{OP_APPLY,    SEL_SLOW, J_ALWAYS, STEP_DLINE, STEP_NONE};
            5'd11: w = '{OP_SEED_AVG, SEL_FAST, J_NEXT,   STEP_NONE, STEP_NONE};
            5'd12: w = '{OP_DLINE,    SEL_FAST, J_SIG,    STEP_OUT, STEP_SEED_SIG};
            5'd13: w = '{OP_DIFF,     SEL_SIG,  J_NEXT,   STEP_NONE, STEP_NONE};
            5'd14: w = '{OP_MLO,      SEL_SIG,  J_NEXT,   STEP_NONE, STEP_NONE};
            5'd15: w = '{OP_MHI,      SEL_SIG,  J_NEXT,   STEP_NONE, STEP_NONE};
            5'd16: w = '{OP_SUM,      SEL_SIG,  J_NEXT,   STEP_NONE, STEP_NONE};
            5'd17: w = '{OP_APPLY,    SEL_SIG,  J_ALWAYS, STEP_OUT, STEP_NONE};
            5'd18: w = '{OP_SEED_SIG, SEL_SIG,  J_NEXT,   STEP_NONE, STEP_NONE};
            5'd19: w = '{OP_OUT,      SEL_FAST, J_NEXT,   STEP_NONE, STEP_NONE};
            default: w = '{OP_NOP,    SEL_FAST, J_ALWAYS, STEP_OUT, STEP_NONE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[hdl/macd_indicator_stream.sv]
// MACD indicator stream: microcoded sequencer, shared 25x17 multiplier and result register.
// Depends on macd_pkg (formats, register map, control store).
`timescale 1ns / 1ps
`default_nettype none

// One closing price (unsigned Q24.8) enters per item, with a flag that starts a new
// series; one result leaves per item: diff line, signal line and histogram in signed
// Q.24 and the warm-up phase. Fast and slow averages seed on the price at index
// slow_period-1, the signal average seeds on the diff line at slow+signal-1, and
// then each moves toward its input by alpha (Q1.16, values above one act as one),
// the step rounded half away from zero. Each item walks a 20-word control program
// that time-shares one 25x17 multiplier across the three averages: an update costs
// five steps (difference, two partial products, round, apply). Before the slow seed
// an item goes straight to the output step; from then on it seeds (at the slow seed)
// or updates both averages, forms the diff line and, from the signal seed on, seeds
// or updates the signal. The output step waits while the result register is full.
// The result sits in an output register, so the next item is taken
// while a result still waits to be read. Registers are written through a separate
// port that is always ready; write them only while idle. The fast period only shapes
// the alpha that software computes, so a write to it is accepted and holds nothing.
module macd_indicator_stream (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // input items
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire  [macd_pkg::PRICE_BITS-1:0]    i_close_price,
    input  wire                                i_series_start,
    // result items
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic signed [macd_pkg::OUT_W-1:0]  o_diff_line,
    output logic signed [macd_pkg::OUT_W-1:0]  o_signal_line,
    output logic signed [macd_pkg::OUT_W-1:0]  o_histogram,
    output logic [macd_pkg::PHASE_W-1:0]       o_warm_phase,
    // configuration writes
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [macd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [macd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import macd_pkg::*;

    localparam int EXT_W = OUT_W - AVG_W;

    // configuration
    logic [PERIOD_W-1:0] r_slow_period, r_signal_period;
    logic [ALPHA_W-1:0]  r_fast_alpha, r_slow_alpha, r_signal_alpha;

    // series state
    logic [IDX_W-1:0]        r_idx;
    logic [AVG_W-1:0]        r_fast, r_slow;
    logic signed [OUT_W-1:0] r_sig;
    logic signed [OUT_W-1:0] r_diff;
    logic [AVG_W-1:0]        r_x;

    // sequencer and datapath registers
    logic                    r_busy;
    logic [STEP_W-1:0]       r_step;
    logic [MAG_W-1:0]        r_mag;
    logic                    r_neg;
    logic [PLO_W-1:0]        r_plo;
    logic [PHI_W-1:0]        r_phi;
    logic [MAG_W-1:0]        r_rstep;

    // result register
    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_out_diff, r_out_sig, r_out_hist;
    logic [PHASE_W-1:0]      r_out_phase;

    t_uword                  uw;
    logic [STEP_W-1:0]       n_step;
    logic                    in_take, out_free, out_load;
    logic [PERIOD_W-1:0]     seed_slow;
    logic [PERIOD_W:0]       sum_periods, seed_sig;
    logic                    lt_slow, eq_slow, lt_sig, eq_sig;
    logic signed [OUT_W-1:0] a_op, x_op, d_op, apply_res;
    logic [ALPHA_W-1:0]      alpha_raw, alpha_c;
    logic [LO_W-1:0]         mul_a;
    logic [PLO_W-1:0]        mul_p;
    logic [SUM_W-1:0]        prod_sum;
    logic signed [OUT_W-1:0] n_diff_o, n_hist_o;
    t_phase                  n_phase;

    assign in_take  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign out_load = r_busy && (uw.op == OP_OUT) && out_free;

    // seed points; a zero slow period seeds on index zero
    assign seed_slow   = (r_slow_period != '0) ? r_slow_period - 1'b1 : '0;
    assign sum_periods = {1'b0, r_slow_period} + {1'b0, r_signal_period};
    assign seed_sig    = (sum_periods != '0) ? sum_periods - 1'b1 : '0;
    assign lt_slow     = r_idx <  IDX_W'(seed_slow);
    assign eq_slow     = r_idx == IDX_W'(seed_slow);
    assign lt_sig      = r_idx <  IDX_W'(seed_sig);
    assign eq_sig      = r_idx == IDX_W'(seed_sig);

    assign uw = ucode(r_step);

    // operand select for the shared update path
    always_comb begin
        unique case (uw.sel)
            SEL_FAST: begin
                a_op      = {{EXT_W{1'b0}}, r_fast};
                alpha_raw = r_fast_alpha;
            end
            SEL_SLOW: begin
                a_op      = {{EXT_W{1'b0}}, r_slow};
                alpha_raw = r_slow_alpha;
            end
            SEL_SIG: begin
                a_op      = r_sig;
                alpha_raw = r_signal_alpha;
            end
            default: begin
                a_op      = r_sig;
                alpha_raw = r_signal_alpha;
            end
        endcase
        x_op = (uw.sel == SEL_SIG) ? r_diff : {{EXT_W{1'b0}}, r_x};
    end

    assign alpha_c   = (alpha_raw > ALPHA_ONE) ? ALPHA_ONE : alpha_raw;
    assign d_op      = x_op - a_op;
    // one multiplier serves both halves of the magnitude
    assign mul_a     = (uw.op == OP_MHI) ? LO_W'(r_mag[MAG_W-1:LO_W]) : r_mag[LO_W-1:0];
    assign mul_p     = mul_a * alpha_c;
    assign prod_sum  = SUM_W'(r_plo) + {r_phi, {LO_W{1'b0}}} + ROUND_HALF;
    assign apply_res = r_neg ? a_op - $signed({{(OUT_W-MAG_W){1'b0}}, r_rstep})
                             : a_op + $signed({{(OUT_W-MAG_W){1'b0}}, r_rstep});

    // result fields; before the slow seed the diff line reads as zero
    always_comb begin
        n_diff_o = lt_slow ? '0 : r_diff;
        n_hist_o = (n_diff_o - r_sig) <<< 1;
        if (lt_slow)     n_phase = PHASE_COLD;
        else if (lt_sig) n_phase = PHASE_DIFF;
        else             n_phase = PHASE_SIGNAL;
    end

    // step counter: jumps and a hold on the output step while the result waits
    always_comb begin
        n_step = r_step + 1'b1;
        unique case (uw.jmp)
            J_NEXT:   n_step = r_step + 1'b1;
            J_ALWAYS: n_step = uw.tgt_a;
            J_SLOW: begin
                if (lt_slow)      n_step = uw.tgt_a;
                else if (eq_slow) n_step = uw.tgt_b;
            end
            J_SIG: begin
                if (lt_sig)       n_step = uw.tgt_a;
                else if (eq_sig)  n_step = uw.tgt_b;
            end
            default: n_step = uw.tgt_a;
        endcase
        if (uw.op == OP_OUT) n_step = r_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_period   <= PERIOD_W'(26);
            r_signal_period <= PERIOD_W'(9);
            r_fast_alpha    <= ALPHA_W'(10082);
            r_slow_alpha    <= ALPHA_W'(4855);
            r_signal_alpha  <= ALPHA_W'(13107);
            r_idx           <= '0;
            r_fast          <= '0;
            r_slow          <= '0;
            r_sig           <= '0;
            r_busy          <= 1'b0;
            r_step          <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            // register writes; unknown indexes drop
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_FAST_PERIOD:   ;
                    CFG_SLOW_PERIOD:   r_slow_period   <= i_cfg_data[PERIOD_W-1:0];
                    CFG_SIGNAL_PERIOD: r_signal_period <= i_cfg_data[PERIOD_W-1:0];
                    CFG_FAST_ALPHA:    r_fast_alpha    <= i_cfg_data;
                    CFG_SLOW_ALPHA:    r_slow_alpha    <= i_cfg_data;
                    CFG_SIGNAL_ALPHA:  r_signal_alpha  <= i_cfg_data;
                    default: ;
                endcase
            end

            // drop valid once taken, unless the next result loads on the same edge
            if (o_out_valid && i_out_ready && !out_load) r_out_valid <= 1'b0;

            // take an item; a series start clears the state first
            if (in_take) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_x    <= {i_close_price, {PRICE_SHIFT{1'b0}}};
                if (i_series_start) begin
                    r_idx  <= '0;
                    r_fast <= '0;
                    r_slow <= '0;
                    r_sig  <= '0;
                end
            end

            if (r_busy) begin
                r_step <= n_step;
                unique case (uw.op)
                    OP_NOP: ;
                    OP_DIFF: begin
                        r_neg <= d_op[OUT_W-1];
                        r_mag <= d_op[OUT_W-1] ? MAG_W'(-d_op) : MAG_W'(d_op);
                    end
                    OP_MLO: r_plo <= mul_p;
                    OP_MHI: r_phi <= PHI_W'(mul_p);
                    OP_SUM: r_rstep <= prod_sum[ALPHA_FRAC +: MAG_W];
                    OP_APPLY: begin
                        unique case (uw.sel)
                            SEL_FAST: r_fast <= apply_res[AVG_W-1:0];
                            SEL_SLOW: r_slow <= apply_res[AVG_W-1:0];
                            SEL_SIG:  r_sig  <= apply_res;
                            default:  r_sig  <= apply_res;
                        endcase
                    end
                    OP_SEED_AVG: begin
                        r_fast <= r_x;
                        r_slow <= r_x;
                    end
                    OP_DLINE: r_diff <= $signed({{EXT_W{1'b0}}, r_fast})
                                      - $signed({{EXT_W{1'b0}}, r_slow});
                    OP_SEED_SIG: r_sig <= r_diff;
                    OP_OUT: begin
                        // hold until the result register is free
                        if (out_free) begin
                            r_out_valid <= 1'b1;
                            r_out_diff  <= n_diff_o;
                            r_out_sig   <= r_sig;
                            r_out_hist  <= n_hist_o;
                            r_out_phase <= n_phase;
                            r_busy      <= 1'b0;
                            if (r_idx != IDX_MAX) r_idx <= r_idx + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_in_ready    = !r_busy;
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_diff_line   = r_out_diff;
    assign o_signal_line = r_out_sig;
    assign o_histogram   = r_out_hist;
    assign o_warm_phase  = r_out_phase;

    // the program never runs past its output step
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_step <= STEP_OUT)
        else $error("step counter left the program");

    // an accepted item restarts the program at its first step
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_busy && r_step == '0)
        else $error("item did not start the program");

    // a cold result carries a zero diff line and never an undefined phase
    a_cold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_warm_phase != 2'd3 &&
                        (o_warm_phase != PHASE_COLD || o_diff_line == '0))
        else $error("bad warm-up result");

    // the output step retires the item only when the result register takes it
    a_retire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && uw.op == OP_OUT && !out_free |=> r_busy && r_step == STEP_OUT)
        else $error("item retired while result register was full");

endmodule

`default_nettype wire
